[design/edh_pkg.sv]
// Shared constants, codes and types of the edge dissimilarity histogram.
`default_nettype none
package edh_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_HEIGHT   = 4096;
  localparam int MAX_CHANNELS = 4;

  localparam int CH_W     = 8;
  localparam int NUM_CH   = 4;
  localparam int CH_USED  = (MAX_CHANNELS < NUM_CH) ? MAX_CHANNELS : NUM_CH;
  localparam int PIX_W    = CH_W * NUM_CH;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int DIM_W    = 13;
  localparam int NCH_W    = 3;

  localparam int CMD_W    = 2;
  localparam int KIND_W   = 2;
  localparam int IDX_W    = 25;
  localparam int P_W      = IDX_W - 1;
  localparam int BIN_W    = 8;
  localparam int NUM_BINS = 1 << BIN_W;
  localparam int COUNT_W  = 26;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);
  localparam logic [NCH_W-1:0] NCH_RST    = NCH_W'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd2;

  localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START = 2'd2;

  localparam logic [KIND_W-1:0] KIND_VERT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HORIZ = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BIN   = 2'd2;

  typedef enum logic [1:0] {
    HOP_NONE,
    HOP_INC,
    HOP_READ,
    HOP_CLEAR
  } hop_t;

  typedef struct packed {
    hop_t             op;
    logic [BIN_W-1:0] addr;
  } hist_req_t;

  typedef struct packed {
    logic [KIND_W-1:0]  result_kind;
    logic [IDX_W-1:0]   edge_index;
    logic [CH_W-1:0]    dissimilarity;
    logic [COUNT_W-1:0] bin_count;
    logic               last_of_run;
  } result_t;

endpackage
`default_nettype wire

[design/edh_in_if.sv]
// Input channel: command, pixel channels and bin select with valid/ready.
`default_nettype none
interface edh_in_if;
  logic                       valid;
  logic                       ready;
  logic [edh_pkg::CMD_W-1:0]  command;
  logic [edh_pkg::CH_W-1:0]   sample_c0;
  logic [edh_pkg::CH_W-1:0]   sample_c1;
  logic [edh_pkg::CH_W-1:0]   sample_c2;
  logic [edh_pkg::CH_W-1:0]   sample_c3;
  logic [edh_pkg::BIN_W-1:0]  bin_select;

  modport source (
    output valid, command, sample_c0, sample_c1, sample_c2, sample_c3, bin_select,
    input  ready
  );
  modport sink (
    input  valid, command, sample_c0, sample_c1, sample_c2, sample_c3, bin_select,
    output ready
  );
endinterface
`default_nettype wire

[design/edh_out_if.sv]
// Result channel: edge or bin read word with valid/ready.
`default_nettype none
interface edh_out_if;
  logic                         valid;
  logic                         ready;
  logic [edh_pkg::KIND_W-1:0]   result_kind;
  logic [edh_pkg::IDX_W-1:0]    edge_index;
  logic [edh_pkg::CH_W-1:0]     dissimilarity;
  logic [edh_pkg::COUNT_W-1:0]  bin_count;
  logic                         last_of_run;

  modport source (
    output valid, result_kind, edge_index, dissimilarity, bin_count, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, result_kind, edge_index, dissimilarity, bin_count, last_of_run,
    output ready
  );
endinterface
`default_nettype wire

[design/edh_hist.sv]
// Histogram store: bin memory with per-bin valid flags and read-modify-write bypass.
`default_nettype none
module edh_hist (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire edh_pkg::hist_req_t            req,
  output logic [edh_pkg::COUNT_W-1:0]        count
);

  logic [edh_pkg::COUNT_W-1:0]  bin_mem [edh_pkg::NUM_BINS];
  logic [edh_pkg::COUNT_W-1:0]  bin_q_r;
  logic [edh_pkg::NUM_BINS-1:0] valid_r;
  edh_pkg::hop_t                op_r;
  logic [edh_pkg::BIN_W-1:0]    addr_r;
  logic                         fwd_vld_r;
  logic [edh_pkg::BIN_W-1:0]    fwd_addr_r;
  logic [edh_pkg::COUNT_W-1:0]  fwd_val_r;
  logic [edh_pkg::COUNT_W-1:0]  inc_val;

  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == addr_r)) begin
      count = fwd_val_r;
    end else if (valid_r[addr_r]) begin
      count = bin_q_r;
    end else begin
      count = '0;
    end
    inc_val = (count == edh_pkg::COUNT_MAX) ? count : count + 1'b1;
  end

  always_ff @(posedge clk) begin
    if ((req.op == edh_pkg::HOP_INC) || (req.op == edh_pkg::HOP_READ)) begin
      bin_q_r <= bin_mem[req.addr];
    end
    if (op_r == edh_pkg::HOP_INC) begin
      bin_mem[addr_r] <= inc_val;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= req.addr;
    fwd_addr_r <= addr_r;
    fwd_val_r  <= inc_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r      <= edh_pkg::HOP_NONE;
      valid_r   <= '0;
      fwd_vld_r <= 1'b0;
    end else begin
      op_r <= req.op;
      unique case (op_r)
        edh_pkg::HOP_INC: begin
          valid_r[addr_r] <= 1'b1;
          fwd_vld_r       <= 1'b1;
        end
        edh_pkg::HOP_CLEAR: begin
          valid_r   <= '0;
          fwd_vld_r <= 1'b0;
        end
        default: begin
          fwd_vld_r <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[design/edh_ofifo.sv]
// Result queue between the histogram stage and the result channel.
`default_nettype none
module edh_ofifo (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             push,
  input  wire edh_pkg::result_t                 push_data,
  input  wire logic                             pop,
  output edh_pkg::result_t                      head,
  output logic                                  not_empty,
  output logic [edh_pkg::FIFO_CNT_W-1:0]        count
);

  edh_pkg::result_t                ent_r [edh_pkg::FIFO_DEPTH];
  logic [edh_pkg::FIFO_PTR_W-1:0]  wr_r;
  logic [edh_pkg::FIFO_PTR_W-1:0]  rd_r;
  logic [edh_pkg::FIFO_CNT_W-1:0]  cnt_r;
  logic                            do_pop;

  assign not_empty = (cnt_r != '0);
  assign do_pop    = pop & not_empty;
  assign head      = ent_r[rd_r];
  assign count     = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
      unique case ({push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

[design/edge_dissimilarity_histogram.sv]
// Top level: raster pixel stream in, edge dissimilarity and histogram bin words out.
// A word is taken on every clock while the result queue has room and each pixel
// yields at most one edge; a pixel with both a vertical and a horizontal edge holds
// the input until its second word is issued, because the result channel moves one
// word per clock and the histogram takes one increment per clock. Results pass the
// item stage, histogram stage and result queue. The previous row lives in a 4096 x 32
// memory read and written at the column on acceptance; the 256 x 26 histogram has a
// valid flag per bin: reset and a start-frame command clear it with no clearing pass.
`default_nettype none
module edge_dissimilarity_histogram (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  edh_in_if.sink                               in_ch,
  edh_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [edh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [edh_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int MUL_W = edh_pkg::ROW_W + edh_pkg::DIM_W;

  function automatic logic [edh_pkg::CH_W-1:0] max_diff(
    input logic [edh_pkg::PIX_W-1:0] a,
    input logic [edh_pkg::PIX_W-1:0] b,
    input logic [edh_pkg::NCH_W-1:0] n
  );
    logic [edh_pkg::CH_W-1:0] best;
    logic [edh_pkg::CH_W-1:0] x;
    logic [edh_pkg::CH_W-1:0] y;
    logic [edh_pkg::CH_W-1:0] d;
    best = '0;
    for (int k = 0; k < edh_pkg::CH_USED; k++) begin
      x = a[edh_pkg::CH_W*k +: edh_pkg::CH_W];
      y = b[edh_pkg::CH_W*k +: edh_pkg::CH_W];
      d = (x > y) ? x - y : y - x;
      if ((k < int'(n)) && (d > best)) begin
        best = d;
      end
    end
    return best;
  endfunction

  // configuration
  logic [edh_pkg::DIM_W-1:0]  width_r;
  logic [edh_pkg::DIM_W-1:0]  height_r;
  logic [edh_pkg::NCH_W-1:0]  nch_r;
  logic [edh_pkg::DIM_W-1:0]  w_eff;
  logic [edh_pkg::DIM_W-1:0]  h_eff;
  logic [edh_pkg::NCH_W-1:0]  nch_eff;

  // position and line state
  logic [edh_pkg::COL_W-1:0]  col_r;
  logic [edh_pkg::ROW_W-1:0]  row_r;
  logic [edh_pkg::PIX_W-1:0]  left_r;
  logic [edh_pkg::PIX_W-1:0]  row_mem [edh_pkg::MAX_WIDTH];
  logic [edh_pkg::PIX_W-1:0]  row_q_r;

  // accept stage
  logic                       in_fire;
  logic                       pix_fire;
  logic                       pos_bad;
  logic [edh_pkg::COL_W-1:0]  c;
  logic [edh_pkg::ROW_W-1:0]  r;
  logic                       c_last;
  logic                       r_last;
  logic [MUL_W-1:0]           p_full;
  logic [edh_pkg::PIX_W-1:0]  cur;
  logic                       has_v;
  logic                       has_h;

  // item stage
  logic                       s1_vld_r;
  logic                       s1_v_r;
  logic                       s1_h_r;
  logic                       s1_rd_r;
  logic                       s1_clr_r;
  logic [edh_pkg::PIX_W-1:0]  s1_cur_r;
  logic [edh_pkg::PIX_W-1:0]  s1_left_r;
  logic [edh_pkg::P_W-1:0]    s1_p_r;
  logic [edh_pkg::BIN_W-1:0]  s1_bin_r;
  logic [edh_pkg::CH_W-1:0]   dis_v;
  logic [edh_pkg::CH_W-1:0]   dis_h;
  logic [edh_pkg::P_W-1:0]    pv;
  logic [edh_pkg::P_W-1:0]    ph;
  logic [edh_pkg::FIFO_CNT_W:0] load;
  logic                       emit;
  logic                       tok_last;
  logic                       s1_done;
  edh_pkg::hist_req_t         req;
  edh_pkg::result_t           res;

  // histogram stage
  logic                       e2_push_r;
  edh_pkg::result_t           e2_res_r;
  edh_pkg::result_t           push_data;
  logic [edh_pkg::COUNT_W-1:0] hist_count;

  // result queue
  edh_pkg::result_t           head;
  logic                       q_not_empty;
  logic [edh_pkg::FIFO_CNT_W-1:0] q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= edh_pkg::WIDTH_RST;
      height_r <= edh_pkg::HEIGHT_RST;
      nch_r    <= edh_pkg::NCH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        edh_pkg::CFG_WIDTH:    width_r  <= cfg_wdata;
        edh_pkg::CFG_HEIGHT:   height_r <= cfg_wdata;
        edh_pkg::CFG_CHANNELS: nch_r    <= cfg_wdata[edh_pkg::NCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (width_r < edh_pkg::DIM_W'(2)) begin
      w_eff = edh_pkg::DIM_W'(2);
    end else if (width_r > edh_pkg::DIM_W'(edh_pkg::MAX_WIDTH)) begin
      w_eff = edh_pkg::DIM_W'(edh_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r < edh_pkg::DIM_W'(2)) begin
      h_eff = edh_pkg::DIM_W'(2);
    end else if (height_r > edh_pkg::DIM_W'(edh_pkg::MAX_HEIGHT)) begin
      h_eff = edh_pkg::DIM_W'(edh_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
    if (nch_r < edh_pkg::NCH_W'(1)) begin
      nch_eff = edh_pkg::NCH_W'(1);
    end else if (nch_r > edh_pkg::NCH_W'(edh_pkg::CH_USED)) begin
      nch_eff = edh_pkg::NCH_W'(edh_pkg::CH_USED);
    end else begin
      nch_eff = nch_r;
    end
  end

  // accept
  assign in_fire  = in_ch.valid & in_ch.ready;
  assign pix_fire = in_fire & (in_ch.command == edh_pkg::CMD_PIXEL);
  assign cur      = {in_ch.sample_c3, in_ch.sample_c2, in_ch.sample_c1, in_ch.sample_c0};

  always_comb begin
    pos_bad = (edh_pkg::DIM_W'(col_r) >= w_eff) || (edh_pkg::DIM_W'(row_r) >= h_eff);
    c       = pos_bad ? '0 : col_r;
    r       = pos_bad ? '0 : row_r;
    c_last  = (edh_pkg::DIM_W'(c) + 1'b1) >= w_eff;
    r_last  = (edh_pkg::DIM_W'(r) + 1'b1) >= h_eff;
    p_full  = MUL_W'(r) * MUL_W'(w_eff) + MUL_W'(c);
    has_v   = (r != '0);
    has_h   = (c != '0);
  end

  always_ff @(posedge clk) begin
    if (pix_fire) begin
      row_q_r    <= row_mem[c];
      row_mem[c] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
    end else if (in_fire) begin
      unique case (in_ch.command)
        edh_pkg::CMD_PIXEL: begin
          left_r <= cur;
          if (c_last) begin
            col_r <= '0;
            row_r <= r_last ? '0 : r + 1'b1;
          end else begin
            col_r <= c + 1'b1;
            row_r <= r;
          end
        end
        edh_pkg::CMD_START: begin
          col_r  <= '0;
          row_r  <= '0;
          left_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // item stage: one result token per clock while the result queue has room
  assign load     = (edh_pkg::FIFO_CNT_W + 1)'(q_count) + (edh_pkg::FIFO_CNT_W + 1)'(e2_push_r);
  assign emit     = s1_vld_r & (load < (edh_pkg::FIFO_CNT_W + 1)'(edh_pkg::FIFO_DEPTH));
  assign tok_last = !(s1_v_r & s1_h_r);
  assign s1_done  = emit & tok_last;
  assign in_ch.ready = !s1_vld_r | s1_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s1_v_r   <= 1'b0;
      s1_h_r   <= 1'b0;
      s1_rd_r  <= 1'b0;
      s1_clr_r <= 1'b0;
    end else if (in_fire) begin
      s1_rd_r  <= (in_ch.command == edh_pkg::CMD_READ);
      s1_clr_r <= (in_ch.command == edh_pkg::CMD_START);
      s1_v_r   <= pix_fire & has_v;
      s1_h_r   <= pix_fire & has_h;
      s1_vld_r <= (in_ch.command == edh_pkg::CMD_READ)
                | (in_ch.command == edh_pkg::CMD_START)
                | (pix_fire & (has_v | has_h));
    end else if (s1_done) begin
      s1_vld_r <= 1'b0;
    end else if (emit) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cur_r  <= cur;
      s1_left_r <= left_r;
      s1_p_r    <= p_full[edh_pkg::P_W-1:0];
      s1_bin_r  <= in_ch.bin_select;
    end
  end

  always_comb begin
    dis_v = max_diff(row_q_r, s1_cur_r, nch_eff);
    dis_h = max_diff(s1_left_r, s1_cur_r, nch_eff);
    pv    = s1_p_r - edh_pkg::P_W'(w_eff);
    ph    = s1_p_r - 1'b1;
    req   = '{op: edh_pkg::HOP_NONE, addr: '0};
    res   = '0;
    res.last_of_run = tok_last;
    priority if (s1_clr_r) begin
      req.op = edh_pkg::HOP_CLEAR;
    end else if (s1_rd_r) begin
      req.op          = edh_pkg::HOP_READ;
      req.addr        = s1_bin_r;
      res.result_kind = edh_pkg::KIND_BIN;
    end else if (s1_v_r) begin
      req.op            = edh_pkg::HOP_INC;
      req.addr          = dis_v;
      res.result_kind   = edh_pkg::KIND_VERT;
      res.edge_index    = {pv, 1'b0};
      res.dissimilarity = dis_v;
    end else begin
      req.op            = edh_pkg::HOP_INC;
      req.addr          = dis_h;
      res.result_kind   = edh_pkg::KIND_HORIZ;
      res.edge_index    = {ph, 1'b1};
      res.dissimilarity = dis_h;
    end
    if (!emit) begin
      req.op = edh_pkg::HOP_NONE;
    end
  end

  // histogram stage
  edh_hist u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .count (hist_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2_push_r <= 1'b0;
    end else begin
      e2_push_r <= emit & !s1_clr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      e2_res_r <= res;
    end
  end

  always_comb begin
    push_data = e2_res_r;
    push_data.bin_count = (e2_res_r.result_kind == edh_pkg::KIND_BIN) ? hist_count : '0;
  end

  edh_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (e2_push_r),
    .push_data (push_data),
    .pop       (out_ch.ready),
    .head      (head),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  assign out_ch.valid         = q_not_empty;
  assign out_ch.result_kind   = head.result_kind;
  assign out_ch.edge_index    = head.edge_index;
  assign out_ch.dissimilarity = head.dissimilarity;
  assign out_ch.bin_count     = head.bin_count;
  assign out_ch.last_of_run   = head.last_of_run;

endmodule
`default_nettype wire

[design/edh_chk.sv]
// Port-level assertions on the result channel, bound to the top level.
`default_nettype none
module edh_chk (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [edh_pkg::KIND_W-1:0]      out_kind,
  input wire logic [edh_pkg::IDX_W-1:0]       out_index,
  input wire logic [edh_pkg::CH_W-1:0]        out_dis,
  input wire logic [edh_pkg::COUNT_W-1:0]     out_count,
  input wire logic                            out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_index)
      && $stable(out_dis) && $stable(out_count) && $stable(out_last))
    else $error("result word changed while stalled");

  a_bin_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == edh_pkg::KIND_BIN) |-> (out_index == '0) && (out_dis == '0)
      && out_last)
    else $error("bin read word malformed");

  a_edge_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != edh_pkg::KIND_BIN) |-> (out_count == '0))
    else $error("edge word carries a bin count");

  a_horiz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == edh_pkg::KIND_HORIZ) |-> out_last && out_index[0])
    else $error("horizontal edge word not last or index even");

  a_vert: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == edh_pkg::KIND_VERT) |-> !out_index[0])
    else $error("vertical edge index odd");

endmodule

bind edge_dissimilarity_histogram edh_chk u_edh_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.result_kind),
  .out_index (out_ch.edge_index),
  .out_dis   (out_ch.dissimilarity),
  .out_count (out_ch.bin_count),
  .out_last  (out_ch.last_of_run)
);
`default_nettype wire

[tb/tb_edge_dissimilarity_histogram.sv]
// Self-checking testbench of the edge dissimilarity histogram: directed and random pixel streams.
`default_nettype none
module tb_edge_dissimilarity_histogram;
  import edh_pkg::*;

  localparam logic [CMD_W-1:0]     CMD_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;
  localparam int                   DRAIN_CYCLES = 8;
  localparam int                   CYCLE_LIMIT  = 500000;
  localparam int                   IDLE_PCT     = 30;
  localparam int                   RANDOM_WORDS = 1550;
  localparam int                   MAX_REPORTS  = 40;

  typedef struct packed {
    logic [CMD_W-1:0]             command;
    logic [NUM_CH-1:0][CH_W-1:0]  sample;
    logic [BIN_W-1:0]             bin_select;
  } in_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  edh_in_if  in_ch();
  edh_out_if out_ch();

  edge_dissimilarity_histogram uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [PIX_W-1:0]   line_mem     [MAX_WIDTH];
  bit                 line_written [MAX_WIDTH];
  logic [PIX_W-1:0]   left_px;
  int unsigned        row_pos;
  int unsigned        col_pos;
  logic [COUNT_W-1:0] bin_counts   [NUM_BINS];
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  logic [NCH_W-1:0]   nch_reg;
  logic [BIN_W-1:0]   hot_bin;
  result_t            pending_results [$];

  bit steady_flow;
  int error_count;
  int words_sent;
  int results_checked;
  int cfg_writes;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic bit idle_now();
    return !steady_flow && ($urandom_range(99) < IDLE_PCT);
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [CH_W-1:0] max_channel_diff(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                                       int unsigned nch);
    logic [CH_W-1:0] best;
    logic [CH_W-1:0] x;
    logic [CH_W-1:0] y;
    logic [CH_W-1:0] d;
    best = '0;
    for (int k = 0; k < nch; k++) begin
      x = a[k*CH_W +: CH_W];
      y = b[k*CH_W +: CH_W];
      d = (x > y) ? x - y : y - x;
      if (d > best) best = d;
    end
    return best;
  endfunction

  function automatic result_t make_result(logic [KIND_W-1:0] kind, int unsigned idx,
                                          logic [CH_W-1:0] dis, logic [COUNT_W-1:0] cnt);
    result_t r;
    r.result_kind   = kind;
    r.edge_index    = IDX_W'(idx);
    r.dissimilarity = dis;
    r.bin_count     = cnt;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  function automatic void count_edge(logic [CH_W-1:0] d);
    if (bin_counts[d] != COUNT_MAX) bin_counts[d] = bin_counts[d] + 1'b1;
    hot_bin = d;
  endfunction

  function automatic void reset_shadow();
    foreach (line_mem[i]) begin
      line_mem[i]     = '0;
      line_written[i] = 1'b0;
    end
    foreach (bin_counts[i]) bin_counts[i] = '0;
    left_px    = '0;
    row_pos    = 0;
    col_pos    = 0;
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
    nch_reg    = NCH_RST;
    hot_bin    = '0;
  endfunction

  function automatic void predict_edges(in_word_t w);
    result_t          res [2];
    int               n;
    int unsigned      wd;
    int unsigned      ht;
    int unsigned      nch;
    int unsigned      p;
    logic [PIX_W-1:0] cur;
    logic [CH_W-1:0]  d;
    n = 0;
    case (w.command)
      CMD_READ: begin
        res[0] = make_result(KIND_BIN, 0, '0, bin_counts[w.bin_select]);
        res[0].last_of_run = 1'b1;
        pending_results.push_back(res[0]);
      end
      CMD_START: begin
        foreach (bin_counts[i]) bin_counts[i] = '0;
        row_pos = 0;
        col_pos = 0;
        left_px = '0;
      end
      CMD_PIXEL: begin
        wd  = clamp_dim(width_reg, 2, MAX_WIDTH);
        ht  = clamp_dim(height_reg, 2, MAX_HEIGHT);
        nch = clamp_dim(nch_reg, 1, CH_USED);
        cur = w.sample;
        if (col_pos >= wd || row_pos >= ht) begin
          row_pos = 0;
          col_pos = 0;
        end
        p = row_pos * wd + col_pos;
        if (row_pos > 0) begin
          d = max_channel_diff(line_mem[col_pos], cur, nch);
          count_edge(d);
          res[n] = make_result(KIND_VERT, (p - wd) << 1, d, '0);
          n++;
        end
        if (col_pos > 0) begin
          d = max_channel_diff(left_px, cur, nch);
          count_edge(d);
          res[n] = make_result(KIND_HORIZ, ((p - 1) << 1) + 1, d, '0);
          n++;
        end
        for (int k = 0; k < n; k++) begin
          res[k].last_of_run = (k == n - 1);
          pending_results.push_back(res[k]);
        end
        line_mem[col_pos]     = cur;
        line_written[col_pos] = 1'b1;
        left_px               = cur;
        if (col_pos + 1 >= wd) begin
          col_pos = 0;
          row_pos = (row_pos + 1 >= ht) ? 0 : row_pos + 1;
        end else begin
          col_pos = col_pos + 1;
        end
      end
      default: ;
    endcase
  endfunction

  // true when the next pixel under these sizes reads only line entries written since reset
  function automatic bit resize_is_safe(int unsigned wd, int unsigned ht);
    if (row_pos == 0 || col_pos >= wd || row_pos >= ht) return 1'b1;
    for (int k = 0; k < wd; k++) begin
      if (!line_written[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [CH_W-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] px;
    for (int k = 0; k < NUM_CH; k++) px[k*CH_W +: CH_W] = rand_sample();
    return px;
  endfunction

  function automatic in_word_t make_word(logic [CMD_W-1:0] cmd, logic [PIX_W-1:0] px,
                                         logic [BIN_W-1:0] bin);
    in_word_t w;
    w.command    = cmd;
    w.sample     = px;
    w.bin_select = bin;
    return w;
  endfunction

  function automatic in_word_t pixel_word(logic [PIX_W-1:0] px);
    return make_word(CMD_PIXEL, px, BIN_W'($urandom_range(255)));
  endfunction

  function automatic in_word_t read_word(logic [BIN_W-1:0] bin);
    return make_word(CMD_READ, $urandom, bin);
  endfunction

  function automatic in_word_t start_word();
    return make_word(CMD_START, $urandom, BIN_W'($urandom_range(255)));
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim();
    case ($urandom_range(19))
      0:       return DIM_W'($urandom_range(1));
      1:       return DIM_W'($urandom_range(MAX_WIDTH, 8191));
      default: return DIM_W'($urandom_range(2, 9));
    endcase
  endfunction

  task automatic send_word(input in_word_t w);
    while (idle_now()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= w.command;
    in_ch.sample_c0  <= w.sample[0];
    in_ch.sample_c1  <= w.sample[1];
    in_ch.sample_c2  <= w.sample[2];
    in_ch.sample_c3  <= w.sample[3];
    in_ch.bin_select <= w.bin_select;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_edges(w);
    words_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_WIDTH:    width_reg  = data;
      CFG_HEIGHT:   height_reg = data;
      CFG_CHANNELS: nch_reg    = data[NCH_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  initial begin : result_monitor
    result_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected word: expected none, actual kind %0d index %0d dis %0d",
                     $time, out_ch.result_kind, out_ch.edge_index, out_ch.dissimilarity);
        end else begin
          want = pending_results.pop_front();
          check_field("result_kind", want.result_kind, out_ch.result_kind);
          check_field("edge_index", want.edge_index, out_ch.edge_index);
          check_field("dissimilarity", want.dissimilarity, out_ch.dissimilarity);
          check_field("bin_count", want.bin_count, out_ch.bin_count);
          check_field("last_of_run", want.last_of_run, out_ch.last_of_run);
          results_checked++;
        end
      end
      out_ch.ready <= rst_n && !idle_now();
    end
  end

  task automatic test_after_reset();
    send_word(read_word(8'd0));
    send_word(pixel_word(32'h00FF_FF00));
    send_word(pixel_word(32'hFF00_00FF));
    send_word(pixel_word(32'h1234_5600));
    send_word(read_word(8'd255));
    send_word(read_word(8'd0));
    send_word(make_word(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF));
    send_word(start_word());
    send_word(read_word(8'd255));
  endtask

  task automatic test_smallest_frame();
    drain_results();
    write_reg(CFG_WIDTH, CFG_DATA_W'(0));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(1));
    write_reg(CFG_CHANNELS, CFG_DATA_W'(7));
    write_reg(CFG_UNUSED, CFG_DATA_W'(8191));
    send_word(start_word());
    send_word(pixel_word(32'h0000_0000));
    send_word(pixel_word(32'h8000_0000));
    send_word(pixel_word(32'h00FF_0000));
    send_word(pixel_word(32'hFF00_0001));
    // wrap to the top left pixel: no edges
    send_word(pixel_word(32'hFFFF_FFFF));
    send_word(read_word(8'd255));
    send_word(read_word(8'd128));
  endtask

  task automatic test_resize_mid_frame();
    drain_results();
    write_reg(CFG_WIDTH, CFG_DATA_W'(3));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(3));
    write_reg(CFG_CHANNELS, CFG_DATA_W'(0));
    send_word(start_word());
    repeat (5) send_word(pixel_word(rand_pixel()));
    drain_results();
    // column lands outside the narrower row: restart at the top left
    write_reg(CFG_WIDTH, CFG_DATA_W'(2));
    repeat (3) send_word(pixel_word(rand_pixel()));
    drain_results();
    write_reg(CFG_HEIGHT, CFG_DATA_W'(1));
    repeat (2) send_word(pixel_word(rand_pixel()));
  endtask

  task automatic test_widest_rows();
    steady_flow = 1'b1;
    drain_results();
    write_reg(CFG_WIDTH, CFG_DATA_W'(8191));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(2));
    write_reg(CFG_CHANNELS, CFG_DATA_W'(4));
    send_word(start_word());
    repeat (MAX_WIDTH + 6) send_word(pixel_word(rand_pixel()));
    drain_results();
    write_reg(CFG_HEIGHT, CFG_DATA_W'(8191));
    repeat (4) send_word(pixel_word(rand_pixel()));
    drain_results();
    write_reg(CFG_WIDTH, CFG_DATA_W'(MAX_WIDTH));
    repeat (2) send_word(pixel_word(rand_pixel()));
    drain_results();
    write_reg(CFG_WIDTH, CFG_DATA_W'(2));
    repeat (6) send_word(pixel_word(rand_pixel()));
    steady_flow = 1'b0;
  endtask

  task automatic test_random_frames(input int target);
    int               sent;
    int               span;
    int unsigned      frame_px;
    int unsigned      pick;
    int unsigned      wd;
    int unsigned      ht;
    logic [DIM_W-1:0] new_w;
    logic [DIM_W-1:0] new_h;
    sent = 0;
    while (sent < target) begin
      drain_results();
      new_w = width_reg;
      new_h = height_reg;
      if ($urandom_range(1)) new_w = rand_dim();
      if ($urandom_range(1)) new_h = rand_dim();
      if (new_w != width_reg) write_reg(CFG_WIDTH, new_w);
      if (new_h != height_reg) write_reg(CFG_HEIGHT, new_h);
      if ($urandom_range(1)) write_reg(CFG_CHANNELS, CFG_DATA_W'($urandom_range(8191)));
      if ($urandom_range(15) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(8191)));
      wd = clamp_dim(width_reg, 2, MAX_WIDTH);
      ht = clamp_dim(height_reg, 2, MAX_HEIGHT);
      if (!resize_is_safe(wd, ht) || $urandom_range(3) != 0) begin
        send_word(start_word());
        sent++;
      end
      frame_px = wd * ht;
      if (frame_px > 64)
        span = $urandom_range(1, 48);
      else if ($urandom_range(3) == 0)
        span = $urandom_range(1, frame_px);
      else
        span = frame_px * $urandom_range(1, 2);
      for (int k = 0; k < span && sent < target; k++) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          send_word(read_word($urandom_range(1) ? hot_bin : BIN_W'($urandom_range(255))));
          sent++;
        end else if (pick < 10) begin
          send_word(make_word(CMD_UNUSED, rand_pixel(), BIN_W'($urandom_range(255))));
        end else if (pick == 10) begin
          send_word(start_word());
          sent++;
        end
        send_word(pixel_word(rand_pixel()));
        sent++;
      end
    end
  endtask

  initial begin : run_tests
    steady_flow     = 1'b0;
    error_count     = 0;
    words_sent      = 0;
    results_checked = 0;
    cfg_writes      = 0;
    reset_shadow();
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= CMD_PIXEL;
    in_ch.sample_c0  <= '0;
    in_ch.sample_c1  <= '0;
    in_ch.sample_c2  <= '0;
    in_ch.sample_c3  <= '0;
    in_ch.bin_select <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_after_reset();
    test_smallest_frame();
    test_resize_mid_frame();
    test_widest_rows();
    test_random_frames(RANDOM_WORDS);
    drain_results();
    $display("summary: %0d words sent, %0d results checked, %0d register writes, %0d mismatches",
             words_sent, results_checked, cfg_writes, error_count);
    $display("summary: frames from 2x2 up to 4096-pixel rows, 1 to 4 channels, resizing, reads");
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire
